### hdl/plrv_pkg.sv
// Shared types and fixed widths for the per-label running variance unit.
package plrv_pkg;

	localparam int LABEL_W  = 6;
	localparam int POS_W    = 24;
	localparam int CNT_W    = 20;
	localparam int FRAC_W   = 12;
	localparam int MEAN_W   = POS_W + FRAC_W;
	localparam int SUM_W    = 64;
	localparam int SQ_FRAC  = 8;
	localparam int SQ_SHIFT = 2 * FRAC_W - SQ_FRAC;
	localparam int HALF_W   = MEAN_W / 2;
	localparam int PROD_W   = 2 * MEAN_W;
	localparam int STEP_W   = $clog2(MEAN_W);

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 128;
	localparam int OUT_USER_W = 2;

	// tuser bit positions on the result stream
	localparam int USER_REV = 0;
	localparam int USER_SAT = 1;

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [MEAN_W-1:0] mean;
		logic [SUM_W-1:0]  sum;
	} entry_t;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_LOAD = 9'b000000010,
		ST_DIV  = 9'b000000100,
		ST_NEWM = 9'b000001000,
		ST_D2   = 9'b000010000,
		ST_MUL0 = 9'b000100000,
		ST_MUL1 = 9'b001000000,
		ST_SUM  = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

endpackage

### hdl/per_label_running_variance_unit.sv
// Top level: per-label count, running mean and sum of squared deviations of segment durations.

// One segment is taken at a time. A normal update goes from the input transfer through a
// read of the label's entry, a radix-2 restoring divider (one quotient bit per cycle for the
// 36-bit mean delta over the new count), then the new mean, the second deviation, two halves
// of the 18x36 multiplier, the saturating sum with the write-back, and the load of the output
// register. A label whose count is full reports its stored entry straight after the read; a
// label beyond NUM_LABELS reports zero statistics without a read. The input is ready again
// once the result enters the output register, even if it has not yet been taken.
// Statistics are kept in an internal memory with per-entry valid bits cleared by reset.
module per_label_running_variance_unit #(
	parameter int NUM_LABELS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// label[5:0], start_pos[29:6], end_pos[53:30], zero pad
	input  logic [plrv_pkg::IN_DATA_W-1:0]       s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// label_out[5:0], sample_count[25:6], mean_duration[61:26], sum_sq_dev[125:62], zero pad
	output logic [plrv_pkg::OUT_DATA_W-1:0]      m_tdata,
	// reversed[0], saturated[1]
	output logic [plrv_pkg::OUT_USER_W-1:0]      m_tuser
);

	localparam int LW    = plrv_pkg::LABEL_W;
	localparam int PW    = plrv_pkg::POS_W;
	localparam int CW    = plrv_pkg::CNT_W;
	localparam int MW    = plrv_pkg::MEAN_W;
	localparam int SW    = plrv_pkg::SUM_W;
	localparam int HW    = plrv_pkg::HALF_W;
	localparam int PRW   = plrv_pkg::PROD_W;
	localparam int MPW   = HW + MW;
	localparam int DEPTH = (NUM_LABELS < (1 << LW)) ? NUM_LABELS : (1 << LW);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	plrv_pkg::state_t state_q;

	plrv_pkg::entry_t mem [DEPTH];
	plrv_pkg::entry_t rd_q;
	plrv_pkg::entry_t ent;
	logic [DEPTH-1:0] vld_q;

	logic [LW-1:0]         lbl_in;
	logic [PW-1:0]         st_in;
	logic [PW-1:0]         en_in;
	logic                  rev_in;
	logic [MW-1:0]         x_in;
	logic                  in_range;
	logic                  acc_in;

	logic [LW-1:0]         lbl_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  rev_q;
	logic                  sat_q;
	logic [MW-1:0]         x_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         n_q;
	logic [MW-1:0]         mean_q;
	logic [SW-1:0]         sum_q;
	logic                  neg_q;
	logic [MW-1:0]         dmag_q;
	logic [MW-1:0]         quo_q;
	logic [CW-1:0]         rem_q;
	logic [plrv_pkg::STEP_W-1:0] step_q;
	logic [MW-1:0]         nm_q;
	logic [MW-1:0]         d2_q;
	logic [PRW-1:0]        acc_q;

	logic [CW:0]           rem_sh;
	logic                  div_ge;
	logic [CW:0]           rem_sub;
	logic [HW-1:0]         mul_a;
	logic [MPW-1:0]        mul_p;
	logic [SW-1:0]         sq_add;
	logic [SW:0]           sum_ext;
	logic [SW-1:0]         sum_new;
	logic                  ent_neg;
	logic                  out_load;

	logic                  m_tvalid_q;
	logic [plrv_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [plrv_pkg::OUT_USER_W-1:0] m_tuser_q;

	assign lbl_in   = s_tdata[LW-1:0];
	assign st_in    = s_tdata[LW+PW-1:LW];
	assign en_in    = s_tdata[LW+2*PW-1:LW+PW];
	assign rev_in   = en_in < st_in;
	assign x_in     = rev_in ? '0 : {en_in - st_in, {plrv_pkg::FRAC_W{1'b0}}};
	assign in_range = {{(32-LW){1'b0}}, lbl_in} < 32'(DEPTH);
	assign s_tready = (state_q == plrv_pkg::ST_IDLE);
	assign acc_in   = s_tvalid && s_tready;

	// never-written entries read as zero
	assign ent     = vld_q[idx_q] ? rd_q : '0;
	assign ent_neg = x_q < ent.mean;

	// restoring divider step
	assign rem_sh  = {rem_q, quo_q[MW-1]};
	assign div_ge  = rem_sh >= {1'b0, n_q};
	assign rem_sub = rem_sh - {1'b0, n_q};

	// one 18x36 multiplier, used for the low then the high half of dmag
	assign mul_a = (state_q == plrv_pkg::ST_MUL0) ? dmag_q[HW-1:0] : dmag_q[MW-1:HW];
	assign mul_p = MPW'(mul_a) * MPW'(d2_q);

	// Q.24 product to Q.8; the shifted product always fits in 64 bits
	assign sq_add  = SW'(acc_q[PRW-1:plrv_pkg::SQ_SHIFT]);
	assign sum_ext = {1'b0, sum_q} + {1'b0, sq_add};
	assign sum_new = sum_ext[SW] ? '1 : sum_ext[SW-1:0];

	assign out_load = (state_q == plrv_pkg::ST_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk) begin
		if (acc_in) begin
			rd_q <= mem[lbl_in[IDX_W-1:0]];
		end
		if (state_q == plrv_pkg::ST_SUM) begin
			mem[idx_q] <= '{cnt: n_q, mean: nm_q, sum: sum_new};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= plrv_pkg::ST_IDLE;
			vld_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (state_q == plrv_pkg::ST_SUM) begin
				vld_q[idx_q] <= 1'b1;
			end
			case (state_q)
				plrv_pkg::ST_IDLE: begin
					if (acc_in) begin
						state_q <= in_range ? plrv_pkg::ST_LOAD : plrv_pkg::ST_DONE;
					end
				end
				plrv_pkg::ST_LOAD: begin
					state_q <= (ent.cnt == '1) ? plrv_pkg::ST_DONE : plrv_pkg::ST_DIV;
				end
				plrv_pkg::ST_DIV: begin
					if (step_q == plrv_pkg::STEP_W'(MW - 1)) begin
						state_q <= plrv_pkg::ST_NEWM;
					end
				end
				plrv_pkg::ST_NEWM: state_q <= plrv_pkg::ST_D2;
				plrv_pkg::ST_D2:   state_q <= plrv_pkg::ST_MUL0;
				plrv_pkg::ST_MUL0: state_q <= plrv_pkg::ST_MUL1;
				plrv_pkg::ST_MUL1: state_q <= plrv_pkg::ST_SUM;
				plrv_pkg::ST_SUM:  state_q <= plrv_pkg::ST_DONE;
				plrv_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= plrv_pkg::ST_IDLE;
					end
				end
				default: state_q <= plrv_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			plrv_pkg::ST_IDLE: begin
				if (acc_in) begin
					lbl_q  <= lbl_in;
					idx_q  <= lbl_in[IDX_W-1:0];
					rev_q  <= rev_in;
					x_q    <= x_in;
					sat_q  <= 1'b0;
					cnt_q  <= '0;
					mean_q <= '0;
					sum_q  <= '0;
				end
			end
			plrv_pkg::ST_LOAD: begin
				cnt_q  <= ent.cnt;
				mean_q <= ent.mean;
				sum_q  <= ent.sum;
				sat_q  <= (ent.cnt == '1);
				n_q    <= ent.cnt + 1'b1;
				neg_q  <= ent_neg;
				dmag_q <= ent_neg ? ent.mean - x_q : x_q - ent.mean;
				quo_q  <= ent_neg ? ent.mean - x_q : x_q - ent.mean;
				rem_q  <= '0;
				step_q <= '0;
			end
			plrv_pkg::ST_DIV: begin
				rem_q  <= div_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
				quo_q  <= {quo_q[MW-2:0], div_ge};
				step_q <= step_q + 1'b1;
			end
			plrv_pkg::ST_NEWM: begin
				nm_q <= neg_q ? mean_q - quo_q : mean_q + quo_q;
			end
			plrv_pkg::ST_D2: begin
				d2_q <= neg_q ? nm_q - x_q : x_q - nm_q;
			end
			plrv_pkg::ST_MUL0: begin
				acc_q <= PRW'(mul_p);
			end
			plrv_pkg::ST_MUL1: begin
				acc_q <= acc_q + (PRW'(mul_p) << HW);
			end
			plrv_pkg::ST_SUM: begin
				cnt_q  <= n_q;
				mean_q <= nm_q;
				sum_q  <= sum_new;
			end
			plrv_pkg::ST_DONE: begin
				if (out_load) begin
					m_tdata_q <= {2'b00, sum_q, mean_q, cnt_q, lbl_q};
					m_tuser_q <= {sat_q, rev_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### hdl/plrv_checker.sv
// Port-level checks for the per-label running variance unit, bound to the top level.
module plrv_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic [plrv_pkg::IN_DATA_W-1:0]       s_tdata,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [plrv_pkg::OUT_DATA_W-1:0]      m_tdata,
	input logic [plrv_pkg::OUT_USER_W-1:0]      m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one segment in flight: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// saturated flag only with a full count
	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[plrv_pkg::USER_SAT] |-> m_tdata[25:6] == '1)
		else $error("saturated without full count");

	// a zero count carries no statistics
	a_zero_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[25:6] == '0) |-> m_tdata[127:26] == '0)
		else $error("statistics with zero count");

	// every input transfer is answered by a result within the update time
	a_answered: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##[1:64] m_tvalid)
		else $error("no result after input transfer");

endmodule

bind per_label_running_variance_unit plrv_checker u_plrv_checker (.*);

### tb/tb_per_label_running_variance_unit.sv
// Testbench for the per-label running variance unit: directed segment table, then random segments.
`timescale 1ns / 1ps

module tb_per_label_running_variance_unit;

	localparam int LABEL_W    = plrv_pkg::LABEL_W;
	localparam int POS_W      = plrv_pkg::POS_W;
	localparam int CNT_W      = plrv_pkg::CNT_W;
	localparam int FRAC_W     = plrv_pkg::FRAC_W;
	localparam int MEAN_W     = plrv_pkg::MEAN_W;
	localparam int SUM_W      = plrv_pkg::SUM_W;
	localparam int SQ_SHIFT   = plrv_pkg::SQ_SHIFT;
	localparam int IN_DATA_W  = plrv_pkg::IN_DATA_W;
	localparam int OUT_DATA_W = plrv_pkg::OUT_DATA_W;
	localparam int OUT_USER_W = plrv_pkg::OUT_USER_W;
	localparam int USER_REV   = plrv_pkg::USER_REV;
	localparam int USER_SAT   = plrv_pkg::USER_SAT;

	localparam int N_LABELS = 64;
	localparam int N_DIR    = 18;
	localparam int N_RAND   = 1450;
	// hot label phase: long alternating run on one label, pushes the sum into saturation
	localparam int HOT_ITEMS = 1250;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// one segment, plus an expected result where it is obvious
	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic [POS_W-1:0]   st;
		logic [POS_W-1:0]   en;
		logic               chk;
		logic [CNT_W-1:0]   cnt;
		logic [MEAN_W-1:0]  mean;
		logic [SUM_W-1:0]   sum;
		logic               rev;
		logic               sat;
	} segment_t;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic [CNT_W-1:0]   cnt;
		logic [MEAN_W-1:0]  mean;
		logic [SUM_W-1:0]   sum;
		logic               rev;
		logic               sat;
	} seg_stats_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	logic [CNT_W-1:0]  label_count [N_LABELS];
	logic [MEAN_W-1:0] label_mean  [N_LABELS];
	logic [SUM_W-1:0]  label_sumsq [N_LABELS];

	seg_stats_t stats_due [$];
	int         mismatches = 0;
	bit         quiet = 1'b0;

	segment_t directed_segs [N_DIR] = '{
		// first update after reset
		'{6'd5,  24'h000000, 24'h000000, 1'b1, 20'd1, 36'h0, 64'h0, 1'b0, 1'b0},
		// longest possible segment
		'{6'd63, 24'h000000, 24'hFFFFFF, 1'b1, 20'd1, 36'hFFFFFF000, 64'h0, 1'b0, 1'b0},
		// fully reversed segment
		'{6'd0,  24'hFFFFFF, 24'h000000, 1'b1, 20'd1, 36'h0, 64'h0, 1'b1, 1'b0},
		'{6'd63, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 20'd0, 36'h0, 64'h0, 1'b0, 1'b0},
		'{6'd63, 24'h123456, 24'h12383E, 1'b0, 20'd0, 36'h0, 64'h0, 1'b0, 1'b0},
		'{6'd0,  24'h000000, 24'hFFFFFF, 1'b0, 20'd0, 36'h0, 64'h0, 1'b0, 1'b0},
		'{6'd1,  24'h00000A, 24'h000014, 1'b1, 20'd1, 36'hA000, 64'h0, 1'b0, 1'b0},
		// same duration again: zero deviation
		'{6'd1,  24'h000014, 24'h00001E, 1'b1, 20'd2, 36'hA000, 64'h0, 1'b0, 1'b0},
		'{6'd1,  24'h000000, 24'h000028, 1'b0, 20'd0, 36'h0, 64'h0, 1'b0, 1'b0},
		'{6'd2,  24'hAAAAAA, 24'h555555, 1'b1, 20'd1, 36'h0, 64'h0, 1'b1, 1'b0},
		'{6'd2,  24'h555555, 24'hAAAAAA, 1'b0, 20'd0, 36'h0, 64'h0, 1'b0, 1'b0},
		'{6'd31, 24'h800000, 24'h7FFFFF, 1'b1, 20'd1, 36'h0, 64'h0, 1'b1, 1'b0},
		'{6'd32, 24'h7FFFFF, 24'h800000, 1'b1, 20'd1, 36'h1000, 64'h0, 1'b0, 1'b0},
		'{6'd32, 24'h000000, 24'h000003, 1'b0, 20'd0, 36'h0, 64'h0, 1'b0, 1'b0},
		'{6'd5,  24'h000001, 24'h000000, 1'b1, 20'd2, 36'h0, 64'h0, 1'b1, 1'b0},
		'{6'd42, 24'h000000, 24'h000001, 1'b1, 20'd1, 36'h1000, 64'h0, 1'b0, 1'b0},
		'{6'd42, 24'h000000, 24'h000002, 1'b0, 20'd0, 36'h0, 64'h0, 1'b0, 1'b0},
		'{6'd42, 24'h000000, 24'h000000, 1'b0, 20'd0, 36'h0, 64'h0, 1'b0, 1'b0}
	};

	per_label_running_variance_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Welford update of one label entry
	function automatic seg_stats_t welford_update(input logic [LABEL_W-1:0] lbl,
			input logic [POS_W-1:0] st, input logic [POS_W-1:0] en);
		seg_stats_t        r;
		logic [MEAN_W-1:0] x, m, dmag, inc, nm, d2mag;
		logic [CNT_W-1:0]  n;
		logic [127:0]      prod;
		logic [SUM_W-1:0]  add;
		logic [SUM_W:0]    tot;
		logic              neg;
		r = '0;
		r.label = lbl;
		r.rev = en < st;
		x = r.rev ? '0 : {POS_W'(en - st), {FRAC_W{1'b0}}};
		if (int'(lbl) < N_LABELS) begin
			if (label_count[lbl] == '1) begin
				r.sat = 1'b1;
			end else begin
				n = label_count[lbl] + 1'b1;
				m = label_mean[lbl];
				neg = x < m;
				dmag = neg ? m - x : x - m;
				inc = dmag / MEAN_W'(n);
				nm = neg ? m - inc : m + inc;
				d2mag = neg ? nm - x : x - nm;
				prod = 128'(dmag) * 128'(d2mag);
				prod = prod >> SQ_SHIFT;
				add = (prod[127:64] != '0) ? '1 : prod[63:0];
				tot = {1'b0, label_sumsq[lbl]} + {1'b0, add};
				label_count[lbl] = n;
				label_mean[lbl] = nm;
				label_sumsq[lbl] = tot[SUM_W] ? '1 : tot[SUM_W-1:0];
			end
			r.cnt = label_count[lbl];
			r.mean = label_mean[lbl];
			r.sum = label_sumsq[lbl];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_segment(input segment_t seg);
		seg_stats_t due;
		while (!quiet && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, seg.en, seg.st, seg.label};
		do @(posedge clk); while (!s_tready);
		due = welford_update(seg.label, seg.st, seg.en);
		if (seg.chk) begin
			due.cnt  = seg.cnt;
			due.mean = seg.mean;
			due.sum  = seg.sum;
			due.rev  = seg.rev;
			due.sat  = seg.sat;
		end
		stats_due.push_back(due);
		@(negedge clk);
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= quiet || ($urandom_range(99) >= 14);
		end
	end

	always @(posedge clk) begin
		seg_stats_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (stats_due.size() == 0) begin
				report_mismatch("unexpected transfer", m_tdata[63:0], '0);
			end else begin
				want = stats_due.pop_front();
				check_field("label_out", 64'(m_tdata[5:0]), 64'(want.label));
				check_field("sample_count", 64'(m_tdata[25:6]), 64'(want.cnt));
				check_field("mean_duration", 64'(m_tdata[61:26]), 64'(want.mean));
				check_field("sum_sq_dev", m_tdata[125:62], want.sum);
				check_field("reversed", 64'(m_tuser[USER_REV]), 64'(want.rev));
				check_field("saturated", 64'(m_tuser[USER_SAT]), 64'(want.sat));
			end
		end
	end

	initial begin
		segment_t           seg;
		logic [LABEL_W-1:0] hot_lbl;
		bit                 hot_hi;
		int                 mode;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		for (int i = 0; i < N_LABELS; i++) begin
			label_count[i] = '0;
			label_mean[i]  = '0;
			label_sumsq[i] = '0;
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_segment(directed_segs[i]);

		hot_lbl = LABEL_W'($urandom_range(63));
		hot_hi = 1'b0;
		for (int i = 0; i < N_RAND; i++) begin
			quiet = (i >= 300 && i < 700);
			seg = '0;
			if (i < HOT_ITEMS && $urandom_range(9) != 0) begin
				// alternate near-zero and near-full durations on one label
				seg.label = hot_lbl;
				if (hot_hi) begin
					seg.st = POS_W'($urandom_range(255));
					seg.en = POS_MAX - POS_W'($urandom_range(255));
				end else begin
					seg.st = POS_W'($urandom_range(POS_MAX));
					if ($urandom_range(1))
						seg.en = seg.st + POS_W'($urandom_range(255));
					else
						seg.en = POS_W'($urandom_range(seg.st));
				end
				hot_hi = !hot_hi;
			end else begin
				seg.label = ($urandom_range(3) == 0) ? LABEL_W'($urandom_range(3))
					: LABEL_W'($urandom_range(63));
				seg.st = POS_W'($urandom_range(POS_MAX));
				mode = $urandom_range(9);
				if (mode < 5)
					seg.en = POS_W'($urandom_range(POS_MAX));
				else if (mode < 8)
					seg.en = seg.st + POS_W'($urandom_range(4095));
				else if (mode == 8)
					seg.en = seg.st;
				else
					seg.en = seg.st - POS_W'(1);
			end
			send_segment(seg);
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		while (stats_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("simulation failed");
		$finish;
	end

endmodule
